/* rtl/sws_pkg.sv */
// shared types, constants and window table of the scope sample scaler
`timescale 1ns / 1ps

package sws_pkg;

    // result and index widths
    localparam int RES_W = 32;
    localparam int IDX_W = 14;

    // window table entry width (largest entry is 500)
    localparam int WIN_W = 10;

    // quotient bits produced by the divider, one per step
    localparam int Q_W       = 41;
    localparam int DIV_STEPS = Q_W;

    // output constants in Q16.16
    localparam logic signed [RES_W-1:0] TEN_Q16 = 32'sd655360;
    localparam logic signed [RES_W-1:0] RES_MAX = 32'sh7fffffff;
    localparam logic signed [RES_W-1:0] RES_MIN = 32'sh80000000;

    typedef struct packed {
        logic [WIN_W-1:0] start;
        logic [WIN_W-1:0] len;
    } win_t;

    // controller to datapath commands
    typedef struct packed {
        logic take;
        logic mul_lo;
        logic mul_hi;
        logic acc;
        logic clamp;
        logic prep;
        logic div_step;
        logic fin;
        logic load;
    } cmd_t;

    // datapath to controller status, valid with a request
    typedef struct packed {
        logic emit;
        logic scale;
    } stat_t;

    // horizontal scale to window start and length, unlisted scales act as 10 ns
    function automatic win_t window_lookup(input logic [15:0] hscale);
        win_t w;
        unique case (hscale)
            16'd1:   w = '{start: 10'd225, len: 10'd50};
            16'd2:   w = '{start: 10'd200, len: 10'd100};
            16'd4:   w = '{start: 10'd150, len: 10'd200};
            default: w = '{start: 10'd0,   len: 10'd500};
        endcase
        return w;
    endfunction

endpackage

/* rtl/sws_dp.sv */
// datapath: decode, record counters, window, multiply, divide and saturate
`timescale 1ns / 1ps

module sws_dp
    import sws_pkg::*;
#(
    parameter int MAX_RECORD = 16384
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output stat_t                   stat,
    input  logic [15:0]             raw_sample,
    input  logic                    start_of_record,
    input  logic [2:0]              sample_format,
    input  logic                    channel_enable,
    input  logic [15:0]             horiz_scale_ns,
    input  logic signed [31:0]      y_offset,
    input  logic signed [31:0]      y_mult,
    input  logic signed [31:0]      y_zero,
    input  logic [30:0]             volts_per_div,
    input  logic signed [31:0]      trace_position,
    output logic signed [RES_W-1:0] res_value,
    output logic [IDX_W-1:0]        res_index,
    output logic                    res_last
);

    localparam int CNT_W = $clog2(MAX_RECORD + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORD);

    localparam logic signed [50:0] V_MAX = 51'sd140737488355327;
    localparam logic signed [50:0] V_MIN = -51'sd140737488355327;
    localparam logic signed [42:0] T_MAX = 43'sd2147483647;
    localparam logic signed [42:0] T_MIN = -43'sd2147483648;

    // record counters
    logic [CNT_W-1:0] ic_reg, ic_next;
    logic [CNT_W-1:0] oc_reg, oc_next;
    logic [CNT_W-1:0] ic_cur, oc_cur;
    logic             full, in_win;
    win_t             win;

    // arithmetic registers
    logic [15:0]              word_val;
    logic signed [16:0]       samp_s;
    logic signed [33:0]       d_next, d_reg;
    logic signed [17:0]       mul_a;
    logic signed [49:0]       prod_w, prod_reg;
    logic signed [65:0]       acc_reg;
    logic signed [49:0]       p_w;
    logic signed [50:0]       sum_w;
    logic signed [47:0]       v_reg;
    logic [46:0]              mag_w;
    logic [30:0]              div_eff;
    logic                     neg_reg, ovf_reg, ovf_w;
    logic [30:0]              rem_reg;
    logic [31:0]              rem2;
    logic                     ge;
    logic [Q_W-1:0]           nq_reg;
    logic signed [42:0]       qmag, qs, t_w;
    logic signed [RES_W-1:0]  fin_val;
    logic signed [RES_W-1:0]  res_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     last_reg;

    // window decision for the incoming sample
    always_comb
    begin
        win    = window_lookup(horiz_scale_ns);
        ic_cur = start_of_record ? '0 : ic_reg;
        oc_cur = start_of_record ? '0 : oc_reg;
        full   = (ic_cur >= MAX_CNT);
        in_win = (ic_cur >= CNT_W'(win.start)) && (oc_cur < CNT_W'(win.len));
        stat.emit  = !full && (!channel_enable || in_win);
        stat.scale = !full && channel_enable && in_win;
        ic_next = full ? ic_cur : ic_cur + 1'b1;
        oc_next = stat.emit ? oc_cur + 1'b1 : oc_cur;
    end

    // counters, updated once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg <= '0;
            oc_reg <= '0;
        end
        else if (cmd.take)
        begin
            ic_reg <= ic_next;
            oc_reg <= oc_next;
        end
    end

    // sample decode and offset removal
    always_comb
    begin
        word_val = sample_format[2] ? raw_sample : {raw_sample[7:0], raw_sample[15:8]};
        if (!sample_format[0])
            samp_s = sample_format[1] ? {{9{raw_sample[7]}}, raw_sample[7:0]}
                                      : {9'b0, raw_sample[7:0]};
        else
            samp_s = sample_format[1] ? {word_val[15], word_val} : {1'b0, word_val};
        d_next = (34'(samp_s) <<< 16) - 34'(y_offset);
    end

    // shared 18x32 multiplier over the two halves of d
    assign mul_a  = cmd.mul_hi ? {d_reg[33], d_reg[33:17]} : {1'b0, d_reg[16:0]};
    assign prod_w = mul_a * y_mult;

    // add y_zero to the floored product and clamp
    assign p_w   = acc_reg[65:16];
    assign sum_w = 51'(p_w) + 51'(y_zero);

    // magnitude and quotient overflow check
    assign div_eff = (volts_per_div == '0) ? 31'd65536 : volts_per_div;
    assign mag_w   = v_reg[47] ? 47'(-v_reg) : 47'(v_reg);
    assign ovf_w   = {9'b0, mag_w} >= {div_eff, 25'b0};

    // one restoring divide step
    assign rem2 = {rem_reg, nq_reg[Q_W-1]};
    assign ge   = (rem2 >= {1'b0, div_eff});

    // sign, position and saturation
    always_comb
    begin
        qmag = {2'b0, nq_reg};
        qs   = neg_reg ? -qmag : qmag;
        t_w  = qs + 43'(trace_position);
        if (ovf_reg)
            fin_val = neg_reg ? RES_MIN : RES_MAX;
        else if (t_w > T_MAX)
            fin_val = RES_MAX;
        else if (t_w < T_MIN)
            fin_val = RES_MIN;
        else
            fin_val = t_w[RES_W-1:0];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            d_reg    <= d_next;
            idx_reg  <= IDX_W'(oc_cur);
            last_reg <= stat.scale && (oc_cur == CNT_W'(win.len - 1'b1));
            if (!channel_enable)
                res_reg <= TEN_Q16;
        end
        if (cmd.mul_lo || cmd.mul_hi)
            prod_reg <= prod_w;
        if (cmd.mul_hi)
            acc_reg <= 66'(prod_reg);
        if (cmd.acc)
            acc_reg <= acc_reg + (66'(prod_reg) <<< 17);
        if (cmd.clamp)
        begin
            if (sum_w > V_MAX)
                v_reg <= 48'(V_MAX);
            else if (sum_w < V_MIN)
                v_reg <= 48'(V_MIN);
            else
                v_reg <= 48'(sum_w);
        end
        if (cmd.prep)
        begin
            neg_reg <= v_reg[47];
            ovf_reg <= ovf_w;
            rem_reg <= {9'b0, mag_w[46:25]};
            nq_reg  <= {mag_w[24:0], 16'b0};
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? 31'(rem2 - {1'b0, div_eff}) : rem2[30:0];
            nq_reg  <= {nq_reg[Q_W-2:0], ge};
        end
        if (cmd.fin)
            res_reg <= fin_val;
    end

    assign res_value = res_reg;
    assign res_index = idx_reg;
    assign res_last  = last_reg;

endmodule

/* rtl/sws_ctrl.sv */
// controller state machine that sequences the scaling datapath
`timescale 1ns / 1ps

module sws_ctrl
    import sws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  out_free,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_CLAMP,
        S_PREP,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    // commands decoded from state
    always_comb
    begin
        cmd          = '0;
        cmd.take     = in_ready && in_valid;
        cmd.mul_lo   = (state_reg == S_MUL_LO);
        cmd.mul_hi   = (state_reg == S_MUL_HI);
        cmd.acc      = (state_reg == S_ACC);
        cmd.clamp    = (state_reg == S_CLAMP);
        cmd.prep     = (state_reg == S_PREP);
        cmd.div_step = (state_reg == S_DIV);
        cmd.fin      = (state_reg == S_FIN);
        cmd.load     = (state_reg == S_OUT) && out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.take)
                begin
                    if (stat.scale)
                        state_next = S_MUL_LO;
                    else if (stat.emit)
                        state_next = S_OUT;
                end
            end
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_ACC;
            S_ACC:    state_next = S_CLAMP;
            S_CLAMP:  state_next = S_PREP;
            S_PREP:
            begin
                state_next = S_DIV;
                cnt_next   = '0;
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_FIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_FIN:    state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // state and divide step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTH
    // a request inside the window starts the multiply
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && stat.scale |=> state_reg == S_MUL_LO)
        else $error("scaled request did not start the multiply");

    // divide counter stays within the step count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg < CNT_W'(DIV_STEPS))
        else $error("divide step counter overran");

    // a finished result waits while the output register is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && !out_free |=> state_reg == S_OUT)
        else $error("result dropped while output busy");
`endif

endmodule

/* rtl/scope_waveform_sample_scaler.sv */
// top level: register file, controller, datapath and output register
`timescale 1ns / 1ps
// A sample inside the window goes MUL_LO, MUL_HI, ACC, CLAMP, PREP, the 41-step restoring
// divider DIV, FIN, OUT, then shows on out_valid; OUT waits while out_free is low. The next
// request is taken in the cycle after the load. Disabled-channel samples go straight to OUT,
// no-result samples stay in IDLE. The output register holds a result while the next runs.
// Reset (rst_n, asynchronous): registers to their reset values, counters to zero, no clear pass.

module scope_waveform_sample_scaler
    import sws_pkg::*;
#(
    parameter int MAX_RECORD = 16384
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // sample channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [15:0]             raw_sample,
    input  logic                    start_of_record,
    // result channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [RES_W-1:0] scaled_value,
    output logic [IDX_W-1:0]        out_index,
    output logic                    last_in_window,
    // register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    typedef enum logic [2:0] {
        REG_FORMAT,
        REG_ENABLE,
        REG_HSCALE,
        REG_YOFF,
        REG_YMULT,
        REG_YZERO,
        REG_VPD,
        REG_POS
    } reg_idx_t;

    logic [2:0]         sample_format_reg;
    logic               channel_enable_reg;
    logic [15:0]        horiz_scale_ns_reg;
    logic signed [31:0] y_offset_reg;
    logic signed [31:0] y_mult_reg;
    logic signed [31:0] y_zero_reg;
    logic [30:0]        volts_per_div_reg;
    logic signed [31:0] trace_position_reg;

    reg_idx_t reg_sel;
    logic     wr_en;

    cmd_t  cmd;
    stat_t stat;
    logic  out_free;

    logic signed [RES_W-1:0] res_value;
    logic [IDX_W-1:0]        res_index;
    logic                    res_last;

    logic                    out_valid_reg;
    logic signed [RES_W-1:0] value_reg;
    logic [IDX_W-1:0]        index_reg;
    logic                    last_reg;

    // register decode
    assign reg_sel = reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_format_reg  <= 3'd0;
            channel_enable_reg <= 1'b0;
            horiz_scale_ns_reg <= 16'd10;
            y_offset_reg       <= 32'sd0;
            y_mult_reg         <= 32'sd65536;
            y_zero_reg         <= 32'sd0;
            volts_per_div_reg  <= 31'd65536;
            trace_position_reg <= 32'sd0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_FORMAT: sample_format_reg  <= pwdata[2:0];
                REG_ENABLE: channel_enable_reg <= pwdata[0];
                REG_HSCALE: horiz_scale_ns_reg <= pwdata[15:0];
                REG_YOFF:   y_offset_reg       <= pwdata;
                REG_YMULT:  y_mult_reg         <= pwdata;
                REG_YZERO:  y_zero_reg         <= pwdata;
                REG_VPD:    volts_per_div_reg  <= pwdata[30:0];
                REG_POS:    trace_position_reg <= pwdata;
                default:    ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_sel)
            REG_FORMAT: prdata = {29'b0, sample_format_reg};
            REG_ENABLE: prdata = {31'b0, channel_enable_reg};
            REG_HSCALE: prdata = {16'b0, horiz_scale_ns_reg};
            REG_YOFF:   prdata = y_offset_reg;
            REG_YMULT:  prdata = y_mult_reg;
            REG_YZERO:  prdata = y_zero_reg;
            REG_VPD:    prdata = {1'b0, volts_per_div_reg};
            REG_POS:    prdata = trace_position_reg;
            default:    prdata = '0;
        endcase
    end

    sws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    sws_dp #(
        .MAX_RECORD (MAX_RECORD)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .raw_sample      (raw_sample),
        .start_of_record (start_of_record),
        .sample_format   (sample_format_reg),
        .channel_enable  (channel_enable_reg),
        .horiz_scale_ns  (horiz_scale_ns_reg),
        .y_offset        (y_offset_reg),
        .y_mult          (y_mult_reg),
        .y_zero          (y_zero_reg),
        .volts_per_div   (volts_per_div_reg),
        .trace_position  (trace_position_reg),
        .res_value       (res_value),
        .res_index       (res_index),
        .res_last        (res_last)
    );

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= res_value;
            index_reg <= res_index;
            last_reg  <= res_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign scaled_value   = value_reg;
    assign out_index      = index_reg;
    assign last_in_window = last_reg;

endmodule
